// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks itself.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expr must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ttsa_pkg.sv
// Shared types, widths and codes for the trip time statistics block.
// No dependencies.
`default_nettype none
package ttsa_pkg;

  localparam int NODE_COUNT = 128;
  localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam int CMD_W  = 2;
  localparam int NODE_W = 7;
  localparam int TIME_W = 16;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POINT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IW-1:0] REG_QUERY_NODE    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_QUERY_TIME    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_START_SLACK   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_TRAVEL_WINDOW = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0]  time_sum;
    logic [CNT_W-1:0]  trip_count;
    logic [TIME_W-1:0] time_min;
    logic [TIME_W-1:0] time_max;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath commands
  typedef struct packed {
    logic ram_rd;      // read table entry of in node, capture operands
    logic do_clear;    // drop all used bits
    logic load_start;  // latch trip start time
    logic do_update;   // write merged entry back
    logic load_out;    // load result register
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic start_ok;
    logic travel_ok;
    logic in_range;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/ttsa_cmd_if.sv
// Command channel: valid/ready plus one command item.
// Depends on ttsa_pkg.
`default_nettype none
interface ttsa_cmd_if import ttsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] node;
  logic [TIME_W-1:0] time_req;

  modport source (output valid, command, node, time_req, input ready);
  modport sink   (input valid, command, node, time_req, output ready);
endinterface
`default_nettype wire

// File: rtl/ttsa_res_if.sv
// Result channel: valid/ready plus one node statistics item.
// Depends on ttsa_pkg.
`default_nettype none
interface ttsa_res_if import ttsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              entry_valid;
  logic [SUM_W-1:0]  time_sum;
  logic [CNT_W-1:0]  trip_count;
  logic [TIME_W-1:0] time_min;
  logic [TIME_W-1:0] time_max;

  modport source (output valid, entry_valid, time_sum, trip_count, time_min, time_max,
                  input ready);
  modport sink   (input valid, entry_valid, time_sum, trip_count, time_min, time_max,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/ttsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ttsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output      logic [WIDTH-1:0]          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/ttsa_ctrl.sv
// Controller: trip/scan flags and the sequencing state machine.
// Depends on ttsa_pkg; drives ctl_t into the datapath.
`default_nettype none
module ttsa_ctrl import ttsa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  output      logic             out_valid,
  input  wire logic             out_ready,
  input  wire stat_t            stat,
  output      ctl_t             ctl
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UPD   = 2'd1;
  localparam logic [1:0] S_RDOUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic active_r, active_nxt;
  logic dest_r, dest_nxt;
  logic fin_r, fin_nxt;
  logic out_valid_r, out_valid_nxt;
  logic take;
  logic out_free;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    dest_nxt      = dest_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_command)
            CMD_CLEAR: begin
              ctl.do_clear = 1'b1;
              active_nxt   = 1'b0;
              dest_nxt     = 1'b0;
              fin_nxt      = 1'b0;
            end
            CMD_START: begin
              if (!fin_r) begin
                if (stat.start_ok) begin
                  ctl.load_start = 1'b1;
                  active_nxt     = 1'b1;
                  dest_nxt       = 1'b1;
                end else begin
                  active_nxt = 1'b0;
                  dest_nxt   = 1'b0;
                  fin_nxt    = 1'b1;
                end
              end
            end
            CMD_POINT: begin
              if (active_r) begin
                if (!dest_r) begin
                  dest_nxt = 1'b1;
                end else if (stat.travel_ok) begin
                  dest_nxt = 1'b0;
                  if (stat.in_range) begin
                    ctl.ram_rd = 1'b1;
                    state_nxt  = S_UPD;
                  end
                end else begin
                  active_nxt = 1'b0;
                  dest_nxt   = 1'b0;
                end
              end
            end
            CMD_READ: begin
              ctl.ram_rd = 1'b1;
              state_nxt  = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        ctl.do_update = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_RDOUT: begin
        if (out_free) begin
          ctl.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      dest_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      dest_r      <= dest_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: rtl/ttsa_dpath.sv
// Datapath: config registers, trip start, used bits, table RAM, merge and result.
// Depends on ttsa_pkg and ttsa_ram; commanded by ttsa_ctrl.
`default_nettype none
module ttsa_dpath import ttsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_idx,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [TIME_W-1:0] in_time,
  input  wire ctl_t              ctl,
  output      stat_t             stat,
  output      logic              res_entry_valid,
  output      logic [SUM_W-1:0]  res_time_sum,
  output      logic [CNT_W-1:0]  res_trip_count,
  output      logic [TIME_W-1:0] res_time_min,
  output      logic [TIME_W-1:0] res_time_max
);
  logic [NODE_W-1:0]  query_node_r;
  logic [TIME_W-1:0]  query_time_r;
  logic [TIME_W-1:0]  start_slack_r;
  logic [TIME_W-1:0]  travel_window_r;
  logic [TIME_W-1:0]  trip_start_r;
  logic [NODE_COUNT-1:0] used_r;

  logic [NODE_AW-1:0] node_idx;
  logic [NODE_AW-1:0] node_idx_r;
  logic [TIME_W-1:0]  travel;
  logic [TIME_W-1:0]  travel_r;
  logic               used_hit_r;
  logic [TIME_W:0]    start_bound;

  entry_t rd_entry, wr_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic [SUM_W:0]     sum_ext;

  logic              res_valid_r;
  entry_t            res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_node_r    <= '0;
      query_time_r    <= '0;
      start_slack_r   <= '0;
      travel_window_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUERY_NODE:    query_node_r    <= cfg_data[NODE_W-1:0];
        REG_QUERY_TIME:    query_time_r    <= cfg_data[TIME_W-1:0];
        REG_START_SLACK:   start_slack_r   <= cfg_data[TIME_W-1:0];
        REG_TRAVEL_WINDOW: travel_window_r <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // start bound kept at 17 bits so it never wraps
  assign start_bound    = {1'b0, query_time_r} + {1'b0, start_slack_r};
  assign travel         = in_time - trip_start_r;
  assign node_idx       = NODE_AW'(in_node);
  assign stat.start_ok  = (in_node == query_node_r) && ({1'b0, in_time} <= start_bound);
  assign stat.travel_ok = (travel < travel_window_r);
  assign stat.in_range  = (32'(in_node) < NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_start_r <= '0;
    end else if (ctl.load_start) begin
      trip_start_r <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ram_rd) begin
      node_idx_r <= node_idx;
      travel_r   <= travel;
      used_hit_r <= stat.in_range && used_r[node_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.do_clear) begin
      used_r <= '0;
    end else if (ctl.do_update) begin
      used_r[node_idx_r] <= 1'b1;
    end
  end

  ttsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ctl.do_update),
    .waddr (node_idx_r),
    .wdata (wr_entry),
    .re    (ctl.ram_rd),
    .raddr (node_idx),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign sum_ext  = {1'b0, rd_entry.time_sum} + (SUM_W + 1)'(travel_r);

  // first trip seeds the entry, later ones merge with saturation
  always_comb begin
    if (!used_hit_r) begin
      wr_entry.time_sum   = SUM_W'(travel_r);
      wr_entry.trip_count = CNT_W'(1);
      wr_entry.time_min   = travel_r;
      wr_entry.time_max   = travel_r;
    end else begin
      wr_entry.time_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      wr_entry.trip_count = (rd_entry.trip_count == CNT_MAX) ? CNT_MAX :
                            rd_entry.trip_count + CNT_W'(1);
      wr_entry.time_min   = (travel_r < rd_entry.time_min) ? travel_r : rd_entry.time_min;
      wr_entry.time_max   = (travel_r > rd_entry.time_max) ? travel_r : rd_entry.time_max;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res_valid_r <= used_hit_r;
      res_r       <= used_hit_r ? rd_entry : '0;
    end
  end

  assign res_entry_valid = res_valid_r;
  assign res_time_sum    = res_r.time_sum;
  assign res_trip_count  = res_r.trip_count;
  assign res_time_min    = res_r.time_min;
  assign res_time_max    = res_r.time_max;
endmodule
`default_nettype wire

// File: rtl/trip_time_stats_aggregator.sv
// Sequence: clear, trip start and boarding points finish in the idle state; a recorded
// destination reads the table, then writes the merged entry back; a read reads the table,
// then loads the output register once the previous result is taken or absent.
// A new command is taken only in the idle state, so a write-back or a waiting result holds off the next.
// Reset (rst_n low, synchronous): config, trip flags and all used bits clear; table
// contents stay undefined and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module trip_time_stats_aggregator import ttsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_idx,
  input  wire logic [CFG_DW-1:0] cfg_data,
  ttsa_cmd_if.sink               in_ch,
  ttsa_res_if.source             out_ch
);
  // Controller holds scan/trip flags and the result valid; the datapath holds
  // config, trip start time, the used-bit vector and the per-node table RAM.
  ctl_t  ctl;
  stat_t stat;

  ttsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  ttsa_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_node         (in_ch.node),
    .in_time         (in_ch.time_req),
    .ctl             (ctl),
    .stat            (stat),
    .res_entry_valid (out_ch.entry_valid),
    .res_time_sum    (out_ch.time_sum),
    .res_trip_count  (out_ch.trip_count),
    .res_time_min    (out_ch.time_min),
    .res_time_max    (out_ch.time_max)
  );

  // a read transaction holds off the next one while the result is formed
  `ASSERT_NEXT(a_read_blocks, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.command == CMD_READ, !in_ch.ready)
  // write-back always follows the table read of its own point
  `ASSERT_AT(a_upd_after_rd, clk, rst_n, ctl.do_update |-> $past(ctl.ram_rd))
  // a result only goes away after it was taken
  `ASSERT_AT(a_out_taken, clk, rst_n, $fell(out_ch.valid) |-> $past(out_ch.ready))
endmodule
`default_nettype wire
